>>> hdl/irq_priority_task_queue_top_assert.svh
// Assertion macros for the interrupt task queue
`ifndef IRQ_PRIORITY_TASK_QUEUE_TOP_ASSERT_SVH
`define IRQ_PRIORITY_TASK_QUEUE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define IPTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define IPTQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define IPTQ_ASSERT(label, prop, msg)
`define IPTQ_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

>>> hdl/iptq_pkg.sv
// Shared types and constants of the interrupt task queue
package iptq_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_REG_W  = 8;

  localparam logic REG_UART_PRIO  = 1'b0;
  localparam logic REG_TIMER_PRIO = 1'b1;

  localparam logic [CFG_REG_W-1:0] UART_PRIO_RESET  = 8'd0;
  localparam logic [CFG_REG_W-1:0] TIMER_PRIO_RESET = 8'd1;

  // UART identify bits 2:1
  localparam logic [1:0] UART_CAUSE_TX = 2'd1;
  localparam logic [1:0] UART_CAUSE_RX = 2'd2;

  localparam int SLOT_OUT_W = 4;

  typedef enum logic [1:0] {
    OP_EVENT    = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_DONE     = 2'd2,
    OP_NOP      = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CODE_NONE    = 2'd0,
    CODE_UART_TX = 2'd1,
    CODE_UART_RX = 2'd2,
    CODE_TIMER   = 2'd3
  } handler_e;

endpackage

>>> hdl/iptq_req_if.sv
// Request channel: interrupt events, dispatch requests and completions
interface iptq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       uart_pending;
  logic [1:0] uart_cause;
  logic       timer_pending;
  logic [3:0] done_slot;

  modport source (
    output valid, opcode, uart_pending, uart_cause, timer_pending, done_slot,
    input  ready
  );
  modport sink (
    input  valid, opcode, uart_pending, uart_cause, timer_pending, done_slot,
    output ready
  );
endinterface

>>> hdl/iptq_rsp_if.sv
// Response channel: one word per request
interface iptq_rsp_if;
  logic       valid;
  logic       ready;
  logic       dispatch_valid;
  logic [1:0] handler_code;
  logic [3:0] task_slot;
  logic [1:0] mask_source;
  logic       insert_dropped;
  logic       queue_empty;

  modport source (
    output valid, dispatch_valid, handler_code, task_slot, mask_source, insert_dropped,
    output queue_empty,
    input  ready
  );
  modport sink (
    input  valid, dispatch_valid, handler_code, task_slot, mask_source, insert_dropped,
    input  queue_empty,
    output ready
  );
endinterface

>>> hdl/irq_priority_task_queue_top.sv
// Interrupt task queue: priority-ordered linked list held in one entry RAM
`include "irq_priority_task_queue_top_assert.svh"

// Deferred interrupt task queue. Tasks live in a RAM of QUEUE_DEPTH entries,
// linked in priority order (lower value first, equal values first in, first
// out); a flop vector marks slots in use and a register holds the list head.
// One request is handled at a time, and its response word is loaded into the
// output register in a final step. An interrupt event that inserts walks the
// list one link per cycle through the RAM's single read port, then writes
// the new entry and up to two neighbor links on the single write port. A
// dispatch reads the head entry and, unless it is already busy, marks it busy
// and reports it; a completion of a slot in use frees it and relinks its
// neighbors. The next request is accepted in the cycle after the response is
// loaded; a response waiting on the output holds back only the following one.
// Priority registers: byte address 0 UART tasks, 4 timer tasks.
module irq_priority_task_queue_top #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  iptq_req_if.sink                         req_i,
  iptq_rsp_if.source                       rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [iptq_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [iptq_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [iptq_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  import iptq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LW-1:0] NIL_LINK = LW'(QUEUE_DEPTH);

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    handler_e                 code;
    logic                     busy;
    logic [LW-1:0]            next;
    logic [LW-1:0]            prev;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_WR_NEW,
    ST_WR_CUR,
    ST_WR_NX,
    ST_DSP_CHK,
    ST_CMP_CHK,
    ST_CMP_WP,
    ST_CMP_WN,
    ST_FIN
  } state_e;

  state_e                   state_q;
  logic [LW-1:0]            head_q;
  logic [QUEUE_DEPTH-1:0]   in_use_q;
  logic [LW-1:0]            cur_q;
  logic [LW-1:0]            nx_q;
  entry_t                   cur_word_q;
  entry_t                   nx_word_q;
  logic [IW-1:0]            slot_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  handler_e                 code_q;

  logic                  res_dv_q;
  handler_e              res_hc_q;
  logic [SLOT_OUT_W-1:0] res_ts_q;
  handler_e              res_ms_q;
  logic                  res_drop_q;

  logic                  out_valid_q;
  logic                  out_dv_q;
  handler_e              out_hc_q;
  logic [SLOT_OUT_W-1:0] out_ts_q;
  handler_e              out_ms_q;
  logic                  out_drop_q;
  logic                  out_empty_q;

  logic [CFG_REG_W-1:0] uart_prio_q;
  logic [CFG_REG_W-1:0] timer_prio_q;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic                     req_fire;
  handler_e                 ev_code;
  logic [PRIORITY_BITS-1:0] ev_prio;
  logic                     free_found;
  logic [IW-1:0]            free_idx;
  logic [IW-1:0]            done_idx;
  logic                     done_hit;
  logic                     head_nil;
  logic                     cfg_wr;
  logic                     cfg_idx;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uart_prio_q  <= UART_PRIO_RESET;
      timer_prio_q <= TIMER_PRIO_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_UART_PRIO:  uart_prio_q  <= pwdata[CFG_REG_W-1:0];
        REG_TIMER_PRIO: timer_prio_q <= pwdata[CFG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_UART_PRIO:  prdata = CFG_DATA_W'(uart_prio_q);
      REG_TIMER_PRIO: prdata = CFG_DATA_W'(timer_prio_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request decode
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign head_nil    = (head_q == NIL_LINK);

  // a UART with another cause masks the timer check as well
  always_comb begin
    ev_code = CODE_NONE;
    ev_prio = '0;
    if (req_i.uart_pending) begin
      if (req_i.uart_cause == UART_CAUSE_TX) begin
        ev_code = CODE_UART_TX;
        ev_prio = PRIORITY_BITS'(uart_prio_q);
      end else if (req_i.uart_cause == UART_CAUSE_RX) begin
        ev_code = CODE_UART_RX;
        ev_prio = PRIORITY_BITS'(uart_prio_q);
      end
    end else if (req_i.timer_pending) begin
      ev_code = CODE_TIMER;
      ev_prio = PRIORITY_BITS'(timer_prio_q);
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign done_idx = IW'(req_i.done_slot);
  assign done_hit = (int'(req_i.done_slot) < QUEUE_DEPTH) && in_use_q[done_idx];

  // ---------------------------------------------------------------------------
  // Entry RAM access
  always_comb begin
    ram_raddr = head_q[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = ram_rdata;
    unique case (state_q)
      ST_IDLE: begin
        if (opcode_e'(req_i.opcode) == OP_DONE) begin
          ram_raddr = done_idx;
        end
      end
      ST_INS_CHK: begin
        ram_raddr = ram_rdata.next[IW-1:0];
      end
      ST_WR_NEW: begin
        ram_we         = 1'b1;
        ram_waddr      = slot_q;
        ram_wdata.prio = prio_q;
        ram_wdata.code = code_q;
        ram_wdata.busy = 1'b0;
        ram_wdata.next = nx_q;
        ram_wdata.prev = cur_q;
      end
      ST_WR_CUR: begin
        ram_we         = 1'b1;
        ram_waddr      = cur_q[IW-1:0];
        ram_wdata      = cur_word_q;
        ram_wdata.next = LW'(slot_q);
      end
      ST_WR_NX: begin
        ram_we         = 1'b1;
        ram_waddr      = nx_q[IW-1:0];
        ram_wdata      = nx_word_q;
        ram_wdata.prev = LW'(slot_q);
      end
      ST_DSP_CHK: begin
        ram_we         = !ram_rdata.busy;
        ram_waddr      = head_q[IW-1:0];
        ram_wdata.busy = 1'b1;
      end
      ST_CMP_CHK: begin
        if (ram_rdata.prev != NIL_LINK) begin
          ram_raddr = ram_rdata.prev[IW-1:0];
        end else begin
          ram_raddr = ram_rdata.next[IW-1:0];
        end
      end
      ST_CMP_WP: begin
        ram_we         = 1'b1;
        ram_waddr      = cur_q[IW-1:0];
        ram_wdata.next = nx_q;
        ram_raddr      = nx_q[IW-1:0];
      end
      ST_CMP_WN: begin
        ram_we         = 1'b1;
        ram_waddr      = nx_q[IW-1:0];
        ram_wdata.prev = cur_q;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  iptq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= NIL_LINK;
      in_use_q    <= '0;
      cur_q       <= NIL_LINK;
      nx_q        <= NIL_LINK;
      cur_word_q  <= '0;
      nx_word_q   <= '0;
      slot_q      <= '0;
      prio_q      <= '0;
      code_q      <= CODE_NONE;
      res_dv_q    <= 1'b0;
      res_hc_q    <= CODE_NONE;
      res_ts_q    <= '0;
      res_ms_q    <= CODE_NONE;
      res_drop_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_dv_q    <= 1'b0;
      out_hc_q    <= CODE_NONE;
      out_ts_q    <= '0;
      out_ms_q    <= CODE_NONE;
      out_drop_q  <= 1'b0;
      out_empty_q <= 1'b1;
    end else begin
      // in ST_FIN the output word is reloaded instead
      if (rsp_o.ready && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            res_dv_q   <= 1'b0;
            res_hc_q   <= CODE_NONE;
            res_ts_q   <= '0;
            res_ms_q   <= (opcode_e'(req_i.opcode) == OP_EVENT) ? ev_code : CODE_NONE;
            res_drop_q <= (opcode_e'(req_i.opcode) == OP_EVENT) && (ev_code != CODE_NONE)
                          && !free_found;
            unique case (opcode_e'(req_i.opcode))
              OP_EVENT: begin
                if (ev_code != CODE_NONE && free_found) begin
                  slot_q  <= free_idx;
                  prio_q  <= ev_prio;
                  code_q  <= ev_code;
                  cur_q   <= NIL_LINK;
                  nx_q    <= head_q;
                  state_q <= head_nil ? ST_WR_NEW : ST_INS_CHK;
                end else begin
                  state_q <= ST_FIN;
                end
              end
              OP_DISPATCH: begin
                state_q <= head_nil ? ST_FIN : ST_DSP_CHK;
              end
              OP_DONE: begin
                if (done_hit) begin
                  slot_q  <= done_idx;
                  state_q <= ST_CMP_CHK;
                end else begin
                  state_q <= ST_FIN;
                end
              end
              OP_NOP:  state_q <= ST_FIN;
              default: state_q <= ST_FIN;
            endcase
          end
        end
        // new task goes before nx_q once nx_q is strictly less urgent
        ST_INS_CHK: begin
          if (prio_q < ram_rdata.prio) begin
            nx_word_q <= ram_rdata;
            state_q   <= ST_WR_NEW;
          end else begin
            cur_q      <= nx_q;
            cur_word_q <= ram_rdata;
            nx_q       <= ram_rdata.next;
            if (ram_rdata.next == NIL_LINK) begin
              state_q <= ST_WR_NEW;
            end
          end
        end
        ST_WR_NEW: begin
          in_use_q[slot_q] <= 1'b1;
          if (cur_q == NIL_LINK) begin
            head_q <= LW'(slot_q);
          end
          priority if (cur_q != NIL_LINK) begin
            state_q <= ST_WR_CUR;
          end else if (nx_q != NIL_LINK) begin
            state_q <= ST_WR_NX;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_WR_CUR: begin
          state_q <= (nx_q != NIL_LINK) ? ST_WR_NX : ST_FIN;
        end
        ST_WR_NX: begin
          state_q <= ST_FIN;
        end
        ST_DSP_CHK: begin
          if (!ram_rdata.busy) begin
            res_dv_q <= 1'b1;
            res_hc_q <= ram_rdata.code;
            res_ts_q <= SLOT_OUT_W'(head_q);
          end
          state_q <= ST_FIN;
        end
        ST_CMP_CHK: begin
          cur_q            <= ram_rdata.prev;
          nx_q             <= ram_rdata.next;
          in_use_q[slot_q] <= 1'b0;
          if (head_q == LW'(slot_q)) begin
            head_q <= ram_rdata.next;
          end
          priority if (ram_rdata.prev != NIL_LINK) begin
            state_q <= ST_CMP_WP;
          end else if (ram_rdata.next != NIL_LINK) begin
            state_q <= ST_CMP_WN;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_CMP_WP: begin
          state_q <= (nx_q != NIL_LINK) ? ST_CMP_WN : ST_FIN;
        end
        ST_CMP_WN: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_dv_q    <= res_dv_q;
            out_hc_q    <= res_hc_q;
            out_ts_q    <= res_ts_q;
            out_ms_q    <= res_ms_q;
            out_drop_q  <= res_drop_q;
            out_empty_q <= head_nil;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.dispatch_valid = out_dv_q;
  assign rsp_o.handler_code   = out_hc_q;
  assign rsp_o.task_slot      = out_ts_q;
  assign rsp_o.mask_source    = out_ms_q;
  assign rsp_o.insert_dropped = out_drop_q;
  assign rsp_o.queue_empty    = out_empty_q;

  // ---------------------------------------------------------------------------
  // Assertions
  `IPTQ_ASSERT(a_head_in_use, head_nil || in_use_q[head_q[IW-1:0]], "head slot is not in use")
  `IPTQ_ASSERT(a_empty_match, head_nil == (in_use_q == '0), "head and slot map disagree")
  `IPTQ_ASSERT_IMPLY(a_walk_used, state_q == ST_INS_CHK, (nx_q != NIL_LINK) && in_use_q[nx_q[IW-1:0]], "walk reached a free slot")
  `IPTQ_ASSERT_IMPLY(a_dispatch_nonempty, out_valid_q && out_dv_q, !out_empty_q, "dispatch reported empty queue")
  `IPTQ_ASSERT_IMPLY(a_word_from_fin, $rose(out_valid_q), $past(state_q == ST_FIN), "response loaded outside finish")

endmodule

>>> hdl/iptq_ram.sv
// Generic single-write, single-read RAM with registered read data
module iptq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
